[design/ptub_pkg.sv]
// ----------------------------------------------------------------------------
// ptub_pkg
// Shared types and constants for the pixel to unit bearing pipeline.
// ----------------------------------------------------------------------------
package ptub_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned SqW    = 2 * ProdW;
  localparam int unsigned SumW   = SqW + 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegFocalX  = 2'd2;
  localparam logic [1:0] RegFocalY  = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] focal_x;
    logic [CoordW-1:0] focal_y;
  } cfg_t;

endpackage

[design/ptub_if.sv]
// ----------------------------------------------------------------------------
// ptub interfaces
// Valid/ready channels for keypoints in and bearings out.
// ----------------------------------------------------------------------------
interface ptub_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ptub_brg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bearing_x;
  logic signed [15:0] bearing_y;
  logic        [14:0] bearing_z;
  modport source (output valid, output bearing_x, output bearing_y, output bearing_z,
                  input ready);
  modport sink   (input valid, input bearing_x, input bearing_y, input bearing_z,
                  output ready);
endinterface

[design/ptub_cfg.sv]
// ----------------------------------------------------------------------------
// ptub_cfg
// APB register file: principal point and focal lengths.
// ----------------------------------------------------------------------------
module ptub_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ptub_pkg::AddrW-1:0] paddr,
  input  logic [ptub_pkg::DataW-1:0] pwdata,
  output logic [ptub_pkg::DataW-1:0] prdata,
  output logic                  pready,
  output ptub_pkg::cfg_t        cfg_o
);
  import ptub_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[3:2])
        RegCenterX: cfg_d.center_x = pwdata[CoordW-1:0];
        RegCenterY: cfg_d.center_y = pwdata[CoordW-1:0];
        RegFocalX:  cfg_d.focal_x  = pwdata[CoordW-1:0];
        RegFocalY:  cfg_d.focal_y  = pwdata[CoordW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegCenterX: prdata = DataW'(cfg_q.center_x);
      RegCenterY: prdata = DataW'(cfg_q.center_y);
      RegFocalX:  prdata = DataW'(cfg_q.focal_x);
      RegFocalY:  prdata = DataW'(cfg_q.focal_y);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.focal_x  <= CoordW'(16);
      cfg_q.focal_y  <= CoordW'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/ptub_front.sv]
// ----------------------------------------------------------------------------
// ptub_front
// Four stages: offsets, products A/B/C, squares, sum of squares D.
// ----------------------------------------------------------------------------
module ptub_front #(
  parameter int unsigned PIXEL_FRAC_BITS = 4
) (
  input  logic                         clk_i,
  input  logic [3:0]                   en_i,
  input  ptub_pkg::cfg_t               cfg_i,
  input  logic [ptub_pkg::CoordW-1:0]  px_i,
  input  logic [ptub_pkg::CoordW-1:0]  py_i,
  output logic                         sx_o,
  output logic                         sy_o,
  output logic [ptub_pkg::SumW-1:0]    d_o,
  output logic [ptub_pkg::SqW-1:0]     n2_o [3]
);
  import ptub_pkg::*;

  localparam logic [CoordW-1:0] FMin = CoordW'(1) << PIXEL_FRAC_BITS;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0] adx_q, ady_q, fx_q, fy_q;
  logic sx1_q, sy1_q, sx2_q, sy2_q, sx3_q, sy3_q, sx4_q, sy4_q;
  logic [ProdW-1:0] a_q, b_q, c_q;
  logic [SqW-1:0]   a2_q, b2_q, c2_q;
  logic [SumW-1:0]  d_q;
  logic [SqW-1:0]   n2_q [3];

  assign dx = $signed({1'b0, px_i}) - $signed({1'b0, cfg_i.center_x});
  assign dy = $signed({1'b0, py_i}) - $signed({1'b0, cfg_i.center_y});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sx1_q <= dx[CoordW];
      sy1_q <= dy[CoordW];
      adx_q <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
      ady_q <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
      fx_q  <= (cfg_i.focal_x < FMin) ? FMin : cfg_i.focal_x;
      fy_q  <= (cfg_i.focal_y < FMin) ? FMin : cfg_i.focal_y;
    end
    if (en_i[1]) begin
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      a_q   <= adx_q * fy_q;
      b_q   <= ady_q * fx_q;
      c_q   <= fx_q * fy_q;
    end
    if (en_i[2]) begin
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      a2_q  <= a_q * a_q;
      b2_q  <= b_q * b_q;
      c2_q  <= c_q * c_q;
    end
    if (en_i[3]) begin
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;
      d_q     <= SumW'(a2_q) + SumW'(b2_q) + SumW'(c2_q);
      n2_q[0] <= a2_q;
      n2_q[1] <= b2_q;
      n2_q[2] <= c2_q;
    end
  end

  assign sx_o = sx4_q;
  assign sy_o = sy4_q;
  assign d_o  = d_q;
  assign n2_o = n2_q;

endmodule

[design/ptub_bit.sv]
// ----------------------------------------------------------------------------
// ptub_bit
// One result bit of round(N*2^F/sqrt(D)) for all three components.
// Tracks S = m^2*D and P = m*D with m = 2q-1, so no multiplier is needed.
// ----------------------------------------------------------------------------
module ptub_bit #(
  parameter int unsigned K   = 0,
  parameter int unsigned QW  = 15,
  parameter int unsigned SW  = 100,
  parameter int unsigned RSH = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        sx_i,
  input  logic                        sy_i,
  input  logic [ptub_pkg::SumW-1:0]   d_i,
  input  logic [ptub_pkg::SqW-1:0]    n2_i [3],
  input  logic signed [SW-1:0]        s_i  [3],
  input  logic signed [SW-1:0]        p_i  [3],
  input  logic [QW-1:0]               q_i  [3],
  output logic                        sx_o,
  output logic                        sy_o,
  output logic [ptub_pkg::SumW-1:0]   d_o,
  output logic [ptub_pkg::SqW-1:0]    n2_o [3],
  output logic signed [SW-1:0]        s_o  [3],
  output logic signed [SW-1:0]        p_o  [3],
  output logic [QW-1:0]               q_o  [3]
);
  import ptub_pkg::*;

  logic signed [SW-1:0] dext;
  logic signed [SW-1:0] cand [3];
  logic signed [SW-1:0] lim  [3];
  logic                 take [3];

  assign dext = $signed(SW'(d_i));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cand[c] = s_i[c] + (p_i[c] <<< (K + 2)) + (dext <<< (2 * K + 2));
      lim[c]  = $signed(SW'(n2_i[c]) << RSH);
      take[c] = cand[c] <= lim[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_o <= sx_i;
      sy_o <= sy_i;
      d_o  <= d_i;
      n2_o <= n2_i;
      for (int c = 0; c < 3; c++) begin
        s_o[c] <= take[c] ? cand[c] : s_i[c];
        p_o[c] <= take[c] ? (p_i[c] + (dext <<< (K + 1))) : p_i[c];
        q_o[c] <= take[c] ? (q_i[c] | (QW'(1) << K)) : q_i[c];
      end
    end
  end

endmodule

[design/pixel_to_unit_bearing.sv]
// ----------------------------------------------------------------------------
// pixel_to_unit_bearing
// Pinhole keypoint (u, v) to unit bearing (nx, ny, 1)/|.| in Q1.15.
//
//   port       dir  kind       payload
//   pixel_i    in   valid/rdy  pixel_x, pixel_y (unsigned Q12.4)
//   bearing_o  out  valid/rdy  bearing_x, bearing_y (signed), bearing_z
//   APB        in   cfg write  center_x/y, focal_x/y at 0x0, 0x4, 0x8, 0xC
//
// One item per cycle while bearing_o.ready holds. Stages: four front
// stages (offset, products, squares, sum), one stage per result bit,
// and the output register. Reset clears valid bits and config registers only.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pixel_to_unit_bearing #(
  parameter int unsigned PIXEL_FRAC_BITS = 4,
  parameter int unsigned OUT_FRAC_BITS   = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ptub_pix_if.sink                   pixel_i,
  ptub_brg_if.source                 bearing_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptub_pkg::AddrW-1:0] paddr,
  input  logic [ptub_pkg::DataW-1:0] pwdata,
  output logic [ptub_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import ptub_pkg::*;

  // result bits per component; caps the magnitude at 2^QW - 1
  localparam int unsigned QW  = (OUT_FRAC_BITS >= 15) ? 15 : OUT_FRAC_BITS;
  // N^2 << (2F+2) plus sign and headroom for the trial sum
  localparam int unsigned RSH = 2 * OUT_FRAC_BITS + 2;
  localparam int unsigned SW  = SqW + RSH + 2;
  localparam int unsigned NS  = 4 + QW + 1;

  cfg_t cfg;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic                 sx_s [QW+1];
  logic                 sy_s [QW+1];
  logic [SumW-1:0]      d_s  [QW+1];
  logic [SqW-1:0]       n2_s [QW+1][3];
  logic signed [SW-1:0] s_s  [QW+1][3];
  logic signed [SW-1:0] p_s  [QW+1][3];
  logic [QW-1:0]        q_s  [QW+1][3];

  logic signed [15:0] bx_q, by_q;
  logic [14:0]        bz_q;
  logic [15:0]        qx16, qy16;

  ptub_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS] = bearing_o.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_q[i] <= (i == 0) ? pixel_i.valid : v_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign pixel_i.ready = en[0];

  ptub_front #(
    .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (en[3:0]),
    .cfg_i (cfg),
    .px_i  (pixel_i.pixel_x),
    .py_i  (pixel_i.pixel_y),
    .sx_o  (sx_s[0]),
    .sy_o  (sy_s[0]),
    .d_o   (d_s[0]),
    .n2_o  (n2_s[0])
  );

  // start with q = 0, i.e. m = -1: S = D, P = -D
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_s[0][c] = $signed(SW'(d_s[0]));
      p_s[0][c] = -$signed(SW'(d_s[0]));
      q_s[0][c] = '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    ptub_bit #(
      .K   (QW - 1 - j),
      .QW  (QW),
      .SW  (SW),
      .RSH (RSH)
    ) u_bit (
      .clk_i (clk_i),
      .en_i  (en[4+j]),
      .sx_i  (sx_s[j]),
      .sy_i  (sy_s[j]),
      .d_i   (d_s[j]),
      .n2_i  (n2_s[j]),
      .s_i   (s_s[j]),
      .p_i   (p_s[j]),
      .q_i   (q_s[j]),
      .sx_o  (sx_s[j+1]),
      .sy_o  (sy_s[j+1]),
      .d_o   (d_s[j+1]),
      .n2_o  (n2_s[j+1]),
      .s_o   (s_s[j+1]),
      .p_o   (p_s[j+1]),
      .q_o   (q_s[j+1])
    );
  end

  // output register: apply offset signs
  assign qx16 = 16'(q_s[QW][0]);
  assign qy16 = 16'(q_s[QW][1]);

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      bx_q <= $signed(sx_s[QW] ? (16'd0 - qx16) : qx16);
      by_q <= $signed(sy_s[QW] ? (16'd0 - qy16) : qy16);
      bz_q <= 15'(q_s[QW][2]);
    end
  end

  assign bearing_o.valid     = v_q[NS-1];
  assign bearing_o.bearing_x = bx_q;
  assign bearing_o.bearing_y = by_q;
  assign bearing_o.bearing_z = bz_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks pixel_to_unit_bearing against an exact integer bearing predictor
// under several camera settings, directed corner keypoints, random keypoints
// and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import ptub_pkg::*;

  localparam int unsigned OutFrac   = 15;
  localparam int unsigned PixFrac   = 4;
  localparam int unsigned Latency   = 5 + OutFrac;
  localparam int unsigned CycleCap  = 1000000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic pready;

  ptub_pix_if pix ();
  ptub_brg_if brg ();

  pixel_to_unit_bearing uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pixel_i(pix.sink), .bearing_o(brg.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [14:0]        bz;
  } bearing_t;

  // shadow of the camera registers
  logic [15:0] cam_cx, cam_cy, cam_fx, cam_fy;
  bearing_t    bearing_q[$];
  int          idle_pct, stall_pct;
  int          errors;
  longint      cycles;

  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("pixel_to_unit_bearing test failed");
      $finish;
    end
  end

  // rounded N*2^F/sqrt(D): largest q with (2q-1)^2*D <= N^2*2^(2F+2)
  function automatic logic [15:0] round_ratio(logic [127:0] n, logic [127:0] d);
    logic [15:0]  q, t;
    logic [255:0] lhs, rhs;
    rhs = (256'(n) * 256'(n)) << (2 * OutFrac + 2);
    q = 16'd0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (16'd1 << b);
      if (t <= 16'd32767) begin
        lhs = 256'(2 * 64'(t) - 1) * 256'(2 * 64'(t) - 1) * 256'(d);
        if (lhs <= rhs) q = t;
      end
    end
    return q;
  endfunction

  function automatic bearing_t predict_bearing(logic [15:0] u, logic [15:0] v);
    logic [63:0]  fx, fy, adx, ady, a, b, c;
    logic [127:0] d;
    logic [15:0]  qx, qy, qz;
    bearing_t     r;
    fx  = (cam_fx < (16'd1 << PixFrac)) ? (64'd1 << PixFrac) : 64'(cam_fx);
    fy  = (cam_fy < (16'd1 << PixFrac)) ? (64'd1 << PixFrac) : 64'(cam_fy);
    adx = (u >= cam_cx) ? 64'(u - cam_cx) : 64'(cam_cx - u);
    ady = (v >= cam_cy) ? 64'(v - cam_cy) : 64'(cam_cy - v);
    a = adx * fy; b = ady * fx; c = fx * fy;
    d = 128'(a) * a + 128'(b) * b + 128'(c) * c;
    qx = round_ratio(a, d); qy = round_ratio(b, d); qz = round_ratio(c, d);
    r.bx = (u < cam_cx) ? -qx : qx;
    r.by = (v < cam_cy) ? -qy : qy;
    r.bz = qz[14:0];
    return r;
  endfunction

  // receiver: random stalls, checks each accepted item against the oldest one due
  always @(posedge clk_i) begin
    bearing_t want;
    if (rst_ni) begin
      if (brg.valid && brg.ready) begin
        if (bearing_q.size() == 0) begin
          $error("unexpected bearing item");
          errors++;
        end else begin
          want = bearing_q.pop_front();
          if (brg.bearing_x !== want.bx) begin
            $error("bearing_x expected %0d actual %0d", want.bx, brg.bearing_x);
            errors++;
          end
          if (brg.bearing_y !== want.by) begin
            $error("bearing_y expected %0d actual %0d", want.by, brg.bearing_y);
            errors++;
          end
          if (brg.bearing_z !== want.bz) begin
            $error("bearing_z expected %0d actual %0d", want.bz, brg.bearing_z);
            errors++;
          end
        end
      end
      brg.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2; pwdata <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegCenterX: cam_cx = val;
      RegCenterY: cam_cy = val;
      RegFocalX:  cam_fx = val;
      default:    cam_fy = val;
    endcase
  endtask

  // drops valid once the sender has nothing more to offer
  task automatic idle_sender();
    pix.valid <= 1'b0;
  endtask

  // waits for the pipeline to drain, then writes the whole camera
  task automatic set_camera(logic [15:0] cx, cy, fx, fy);
    int guard;
    guard = 0;
    idle_sender();
    while (bearing_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 2) @(posedge clk_i);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegFocalX, fx);
    write_reg(RegFocalY, fy);
  endtask

  // sends one keypoint; valid stays high across back-to-back items
  task automatic send_keypoint(logic [15:0] u, logic [15:0] v);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1; pix.pixel_x <= u; pix.pixel_y <= v;
    do @(posedge clk_i); while (!pix.ready);
    bearing_q = {bearing_q, predict_bearing(u, v)};
  endtask

  task automatic test_directed();
    logic [15:0] k [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0010, 16'h1234};
    idle_pct = 0; stall_pct = 0;
    // reset camera: focal 1.0, centre at origin
    send_keypoint(16'h0000, 16'h0000);
    send_keypoint(16'hFFFF, 16'hFFFF);
    // focal below one used as one, including zero
    set_camera(16'h8000, 16'h4000, 16'h0000, 16'h0005);
    for (int i = 0; i < 6; i++) send_keypoint(k[i], k[5 - i]);
    // keypoint on the principal point gives z saturated, x and y zero
    send_keypoint(16'h8000, 16'h4000);
    set_camera(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_keypoint(k[i], k[i]);
    send_keypoint(16'hFFFF, 16'h1000);
    set_camera(16'h1400, 16'h0F00, 16'h2000, 16'h0010);
    for (int i = 0; i < 6; i++) send_keypoint(k[(i + 2) % 6], k[i]);
  endtask

  task automatic random_phase(int n, int ip, int sp);
    logic [15:0] u, v;
    idle_pct = ip; stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin u = 16'($urandom); v = 16'($urandom); end
        1: begin  // near the principal point
          u = cam_cx + 16'($urandom_range(64)) - 16'd32;
          v = cam_cy + 16'($urandom_range(64)) - 16'd32;
        end
        default: begin
          u = cam_cx + 16'($urandom_range(8191)) - 16'd4096;
          v = cam_cy + 16'($urandom_range(8191)) - 16'd4096;
        end
      endcase
      send_keypoint(u, v);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 7; p++) begin
      set_camera(16'($urandom), 16'($urandom),
                 (p == 3) ? 16'd16 : 16'($urandom_range(16, 65535)),
                 (p == 4) ? 16'hFFFF : 16'($urandom_range(0, 20000)));
      case (p % 4)
        0: random_phase(200, 0, 0);
        1: random_phase(200, 79, 0);
        2: random_phase(200, 0, 79);
        default: random_phase(200, 12, 12);
      endcase
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 0; stall_pct = 30;
    for (int i = 0; i < 10; i++) send_keypoint(16'($urandom), 16'($urandom));
    // hold off until every outstanding bearing is back
    idle_sender();
    while (bearing_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 10; i++) send_keypoint(16'($urandom), 16'($urandom));
  endtask

  initial begin
    int guard;
    errors = 0; cycles = 0;
    idle_pct = 0; stall_pct = 0;
    cam_cx = 16'd0; cam_cy = 16'd0; cam_fx = 16'd16; cam_fy = 16'd16;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix.valid = 1'b0; pix.pixel_x = '0; pix.pixel_y = '0;
    brg.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_drain_pause();
    idle_sender();
    stall_pct = 0;
    guard = 0;
    while (bearing_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 5) @(posedge clk_i);
    if (errors == 0 && bearing_q.size() == 0)
      $display("pixel_to_unit_bearing test passed");
    else
      $display("pixel_to_unit_bearing test failed");
    $finish;
  end
endmodule

[filelist.f]
design/ptub_pkg.sv
design/ptub_if.sv
design/ptub_cfg.sv
design/ptub_front.sv
design/ptub_bit.sv
design/pixel_to_unit_bearing.sv
test/testbench.sv
